// ===== hw/rtl/clp_pkg.sv =====
// Shared types and constants of the CR LF command line parser.
package clp_pkg;

	// Widths of the beat fields and of the internal digit terms.
	localparam int BYTE_W  = 8;
	localparam int DIGIT_W = 9;
	localparam int VALUE_W = 19;
	localparam int NUM_DIGITS = 4;

	// Number of leading line positions that the commands ever look at.
	localparam int HEAD_LEN = 7;

	// Character codes.
	localparam logic [BYTE_W-1:0] CHAR_CR   = 8'h0D;
	localparam logic [BYTE_W-1:0] CHAR_LF   = 8'h0A;
	localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_S    = 8'h53;
	localparam logic [BYTE_W-1:0] CHAR_V    = 8'h56;
	localparam logic [BYTE_W-1:0] CHAR_D    = 8'h44;
	localparam logic [BYTE_W-1:0] CHAR_P    = 8'h50;
	localparam logic [BYTE_W-1:0] CHAR_K    = 8'h4B;

	// Decimal weights of the digit terms, most significant first.
	localparam logic signed [VALUE_W-1:0] WEIGHT_3 = 19'sd1000;
	localparam logic signed [VALUE_W-1:0] WEIGHT_2 = 19'sd100;
	localparam logic signed [VALUE_W-1:0] WEIGHT_1 = 19'sd10;

	typedef logic [BYTE_W-1:0] byte_t;

	// Command targets.
	typedef enum logic [1:0] {
		TGT_SERVO_DUTY    = 2'd0,
		TGT_DEFAULT_PULSE = 2'd1,
		TGT_GAIN_P        = 2'd2,
		TGT_GAIN_D        = 2'd3
	} target_t;

	// A decoded command: digit terms are signed, index 3 carries weight 1000.
	typedef struct packed {
		logic                             valid;
		target_t                          target;
		logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digit;
	} cmd_t;

endpackage

// ===== hw/rtl/clp_line_track.sv =====
// Line state, CR LF detection, prefix match and digit selection.
module clp_line_track
	import clp_pkg::*;
#(
	parameter int LINE_DEPTH = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_accept,
	input  byte_t rx_byte,
	input  logic  load,
	output cmd_t  cmd_s1
);

	localparam int FILL_W = $clog2(LINE_DEPTH);

	byte_t              head_q [HEAD_LEN];
	byte_t              prev_q;
	logic [FILL_W-1:0]  fill_q;

	byte_t                       head_next [HEAD_LEN];
	logic signed [DIGIT_W-1:0]   dig [HEAD_LEN];
	logic                        line_full;
	logic                        crlf;
	logic                        hit;
	cmd_t                        cmd_next;

	// Head of the line with the current byte placed at its position.
	always_comb begin
		for (int i = 0; i < HEAD_LEN; i++) begin
			head_next[i] = (fill_q == FILL_W'(i)) ? rx_byte : head_q[i];
			dig[i] = $signed({head_next[i][BYTE_W-1], head_next[i]})
				- $signed({1'b0, CHAR_ZERO});
		end
	end

	assign line_full = (fill_q == FILL_W'(LINE_DEPTH - 1));
	assign crlf = (fill_q != '0) && (prev_q == CHAR_CR) && (rx_byte == CHAR_LF);

	// Prefix match and digit selection; the prefixes exclude each other.
	always_comb begin
		cmd_next = '0;
		hit = 1'b0;
		if (fill_q >= FILL_W'(3) && head_next[0] == CHAR_S && head_next[1] == CHAR_V
			&& head_next[2] == CHAR_D) begin
			hit = 1'b1;
			cmd_next.target = TGT_SERVO_DUTY;
			cmd_next.digit = {dig[3], dig[4], dig[5], dig[6]};
		end else if (fill_q >= FILL_W'(2) && head_next[0] == CHAR_D
			&& head_next[1] == CHAR_P) begin
			hit = 1'b1;
			cmd_next.target = TGT_DEFAULT_PULSE;
			cmd_next.digit = {DIGIT_W'(0), dig[2], dig[3], dig[4]};
		end else if (fill_q >= FILL_W'(4) && head_next[0] == CHAR_S
			&& head_next[1] == CHAR_V && head_next[2] == CHAR_K
			&& (head_next[3] == CHAR_P || head_next[3] == CHAR_D)) begin
			hit = 1'b1;
			cmd_next.target = (head_next[3] == CHAR_P) ? TGT_GAIN_P : TGT_GAIN_D;
			cmd_next.digit = {DIGIT_W'(0), dig[4], dig[5], dig[6]};
		end
		cmd_next.valid = in_accept && !line_full && crlf && hit;
	end

	// Line state: cleared on a full buffer and after every CR LF.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			for (int i = 0; i < HEAD_LEN; i++) head_q[i] <= '0;
		end else if (in_accept) begin
			if (line_full || crlf) begin
				fill_q <= '0;
				for (int i = 0; i < HEAD_LEN; i++) head_q[i] <= '0;
			end else begin
				fill_q <= fill_q + FILL_W'(1);
				for (int i = 0; i < HEAD_LEN; i++) head_q[i] <= head_next[i];
			end
		end
	end

	// The last byte stored; only read while the line holds at least one byte.
	always_ff @(posedge clk) begin
		if (in_accept) prev_q <= rx_byte;
	end

	// Decoded command register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1 <= '0;
		end else if (load) begin
			cmd_s1 <= cmd_next;
		end
	end

	// The fill count never reaches the depth.
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(LINE_DEPTH - 1))
		else $error("fill count out of range");

	// A byte that fills the buffer clears the line.
	a_full_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && line_full |=> fill_q == '0)
		else $error("full buffer not cleared");

	// Three-digit commands carry no thousands term.
	a_three_digit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_s1.valid && cmd_s1.target != TGT_SERVO_DUTY |-> cmd_s1.digit[3] == '0)
		else $error("thousands term on a three-digit command");

endmodule

// ===== hw/rtl/clp_value_calc.sv =====
// Weighted decimal sum and output register of the command parser.
module clp_value_calc
	import clp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd_s1,
	output logic                advance,
	output logic                out_valid,
	input  logic                out_ready,
	output target_t             out_target,
	output logic [VALUE_W-1:0]  out_value
);

	logic signed [VALUE_W-1:0] term3, term2, term1, term0;
	logic signed [VALUE_W-1:0] sum;
	logic                      valid_s2;
	target_t                   target_s2;
	logic [VALUE_W-1:0]        value_s2;

	// Constant multiplies of the sign-extended digit terms.
	always_comb begin
		term3 = VALUE_W'($signed(cmd_s1.digit[3])) * WEIGHT_3;
		term2 = VALUE_W'($signed(cmd_s1.digit[2])) * WEIGHT_2;
		term1 = VALUE_W'($signed(cmd_s1.digit[1])) * WEIGHT_1;
		term0 = VALUE_W'($signed(cmd_s1.digit[0]));
		sum = term3 + term2 + term1 + term0;
	end

	assign advance = !valid_s2 || out_ready;

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= cmd_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && cmd_s1.valid) begin
			target_s2 <= cmd_s1.target;
			value_s2 <= sum;
		end
	end

	assign out_valid = valid_s2;
	assign out_target = target_s2;
	assign out_value = value_s2;

	// Gains and pulses fit the three-digit range.
	a_short_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && target_s2 != TGT_SERVO_DUTY
		|-> $signed(value_s2) >= -19'sd19536 && $signed(value_s2) <= 19'sd8769)
		else $error("three-digit value out of range");

endmodule

// ===== hw/rtl/crlf_command_line_parser.sv =====
// Top level of the CR LF command line parser.
// One received byte is taken per beat, and a beat may follow in every cycle. A line
// ending in CR LF that starts with SVD, DP, SVKP or SVKD gives one result beat: a
// line-state stage decodes the command and a second stage forms the weighted decimal
// value. Other lines, and a byte that fills the LINE_DEPTH buffer, give no result; the
// input stalls only while both stages hold results that the output side has not yet
// taken.
module crlf_command_line_parser
	import clp_pkg::*;
#(
	parameter int LINE_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [18:0] value, [23:19] zero
	output logic [1:0]  m_tuser    // [1:0] target
);

	cmd_t               cmd_s1;
	logic               advance;
	logic               in_accept;
	target_t            out_target;
	logic [VALUE_W-1:0] out_value;

	// The decode stage loads whenever it is empty or the result stage moves.
	assign s_tready = !cmd_s1.valid || advance;
	assign in_accept = s_tvalid && s_tready;

	clp_line_track #(
		.LINE_DEPTH (LINE_DEPTH)
	) u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.rx_byte   (s_tdata),
		.load      (s_tready),
		.cmd_s1    (cmd_s1)
	);

	clp_value_calc u_calc (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_s1     (cmd_s1),
		.advance    (advance),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_target (out_target),
		.out_value  (out_value)
	);

	assign m_tdata = {5'b0, out_value};
	assign m_tuser = out_target;

endmodule
